### src/fbss_pkg.sv
`default_nettype none

package fbss_pkg;

  // Field widths
  localparam int unsigned EDGE_W  = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned AREA_W  = 21;
  localparam int unsigned HELD_W  = 13;
  localparam int unsigned SMTH_W  = 17;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned SCORE_W = 24;
  localparam int unsigned NUM_VAL = 4;

  // Size and factor limits
  localparam logic [SIZE_W-1:0] BOX_MAX    = 11'd1024;
  localparam logic [8:0]        FACTOR_MAX = 9'd256;

  // Register map
  typedef enum logic [1:0] {
    REG_FILTER_FACTOR = 2'd0,
    REG_DEAD_ZONE     = 2'd1,
    REG_FRAME_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT  = 2'd3
  } reg_idx_t;

  localparam logic [8:0]  RST_FILTER_FACTOR = 9'd51;
  localparam logic [9:0]  RST_DEAD_ZONE     = 10'd10;
  localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;

  // Lane order of the tracked values
  localparam int unsigned LANE_CX = 0;
  localparam int unsigned LANE_CY = 1;
  localparam int unsigned LANE_W  = 2;
  localparam int unsigned LANE_H  = 3;

  typedef struct packed {
    logic [8:0]  filter_factor;
    logic [9:0]  dead_zone;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
  } cfg_t;

  // One finished frame, handed from selection to tracking
  typedef struct packed {
    logic              found;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } rec_t;

  typedef struct packed {
    logic               found;
    logic [OUT_W-1:0]   centre_x;
    logic [OUT_W-1:0]   centre_y;
    logic [OUT_W-1:0]   face_width;
    logic [OUT_W-1:0]   face_height;
    logic [SCORE_W-1:0] score;
  } res_t;

endpackage

`default_nettype wire

### src/fbss_fifo.sv
`default_nettype none

module fbss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic                           pop,
  output logic      [WIDTH-1:0]               rdata,
  output logic                                full,
  output logic                                empty,
  output logic      [$clog2(DEPTH+1)-1:0]     count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full fifo");

  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push && cnt_r == CW'(1)) |=> empty)
    else $error("fifo not empty after last entry left");

endmodule

`default_nettype wire

### src/fbss_front.sv
`default_nettype none

module fbss_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       box_valid,
  input  wire logic [9:0]                 box_left,
  input  wire logic [9:0]                 box_top,
  input  wire logic [10:0]                box_width,
  input  wire logic [10:0]                box_height,
  input  wire logic                       frame_end,
  output logic                            rec_push,
  output fbss_pkg::rec_t                  rec
);

  import fbss_pkg::*;

  logic [EDGE_W-1:0] best_left_r, best_top_r;
  logic [SIZE_W-1:0] best_w_r, best_h_r;
  logic [AREA_W-1:0] best_area_r;
  logic              have_best_r;

  logic [SIZE_W-1:0] w_sat, h_sat;
  logic [AREA_W-1:0] area;
  logic              take;

  // Clip sizes and compare areas, first one wins a tie
  always_comb begin
    w_sat = (box_width  > BOX_MAX) ? BOX_MAX : box_width;
    h_sat = (box_height > BOX_MAX) ? BOX_MAX : box_height;
    area  = AREA_W'(w_sat * h_sat);
    take  = accept && box_valid && (!have_best_r || (area > best_area_r));
  end

  // Build the frame record from the winner including this item
  always_comb begin
    rec_push   = accept && frame_end;
    rec.found  = have_best_r || take;
    rec.left   = take ? box_left : best_left_r;
    rec.top    = take ? box_top  : best_top_r;
    rec.width  = take ? w_sat    : best_w_r;
    rec.height = take ? h_sat    : best_h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (accept && frame_end) begin
      have_best_r <= 1'b0;
    end else if (take) begin
      have_best_r <= 1'b1;
    end
  end

  // Hold the current winner
  always_ff @(posedge clk) begin
    if (take) begin
      best_left_r <= box_left;
      best_top_r  <= box_top;
      best_w_r    <= w_sat;
      best_h_r    <= h_sat;
      best_area_r <= area;
    end
  end

  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> !have_best_r)
    else $error("selection not cleared after frame end");

  a_take_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !frame_end) |=> have_best_r)
    else $error("winner not marked");

  a_found_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> rec.found)
    else $error("record lost its rectangle");

endmodule

`default_nettype wire

### src/fbss_back.sv
`default_nettype none

module fbss_back #(
  parameter int unsigned MAX_FRAME_DIM = 2048,
  parameter int unsigned OUT_DEPTH     = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fbss_pkg::cfg_t                    cfg,
  input  wire logic                              rec_avail,
  input  wire fbss_pkg::rec_t                    rec,
  output logic                                   rec_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
  output logic                                   res_push,
  output fbss_pkg::res_t                         res
);

  import fbss_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH+1);
  localparam logic [12:0] DIM_MAX = 13'(MAX_FRAME_DIM);
  localparam logic signed [19:0] SMTH_LO = -20'sd65536;
  localparam logic signed [19:0] SMTH_HI = 20'sd65535;

  // Stage A: derived values of one frame
  logic                     a_valid_r, a_found_r;
  logic signed [HELD_W-1:0] a_val_r [NUM_VAL];
  // Tracking state
  logic signed [HELD_W-1:0] held_r   [NUM_VAL];
  logic signed [SMTH_W-1:0] smooth_r [NUM_VAL];
  // Stage C: result pending on the state just updated
  logic                     c_valid_r, c_found_r;

  logic [CW:0]              pending;
  logic [12:0]              fw_sat, fh_sat;
  logic [10:0]              sum_x, sum_y;
  logic signed [HELD_W-1:0] val_nxt [NUM_VAL];
  logic [8:0]               fac;

  logic signed [13:0]       dz_diff [NUM_VAL];
  logic [13:0]              dz_mag  [NUM_VAL];
  logic signed [HELD_W-1:0] held_nxt [NUM_VAL];
  logic signed [17:0]       flt_diff [NUM_VAL];
  logic signed [27:0]       flt_prod [NUM_VAL];
  logic signed [19:0]       flt_sum  [NUM_VAL];
  logic signed [SMTH_W-1:0] smooth_nxt [NUM_VAL];

  logic [OUT_W-1:0]         sat_cx, sat_cy, sat_w, sat_h;
  logic [31:0]              area_q;

  // Take a frame only when the result queue has room for all in flight
  always_comb begin
    pending = (CW+1)'(out_count) + (CW+1)'(a_valid_r) + (CW+1)'(c_valid_r);
    rec_pop = rec_avail && (pending < (CW+1)'(OUT_DEPTH));
  end

  // Centre offset and full-scale size of the winner
  always_comb begin
    fw_sat = ({1'b0, cfg.frame_width}  > DIM_MAX) ? DIM_MAX : {1'b0, cfg.frame_width};
    fh_sat = ({1'b0, cfg.frame_height} > DIM_MAX) ? DIM_MAX : {1'b0, cfg.frame_height};
    sum_x  = {1'b0, rec.left} + {1'b0, rec.width[10:1]};
    sum_y  = {1'b0, rec.top}  + {1'b0, rec.height[10:1]};
    val_nxt[LANE_CX] = $signed({1'b0, sum_x, 1'b0}) - $signed({1'b0, fw_sat[12:1]});
    val_nxt[LANE_CY] = $signed({1'b0, sum_y, 1'b0}) - $signed({1'b0, fh_sat[12:1]});
    val_nxt[LANE_W]  = $signed({1'b0, rec.width, 1'b0});
    val_nxt[LANE_H]  = $signed({1'b0, rec.height, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= rec_pop;
      c_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      a_found_r <= rec.found;
      for (int k = 0; k < NUM_VAL; k++) begin
        a_val_r[k] <= val_nxt[k];
      end
    end
    c_found_r <= a_found_r;
  end

  // Deadzone then filter: s + floor((f*(16*held - s) + 128) / 256)
  always_comb begin
    fac = (cfg.filter_factor > FACTOR_MAX) ? FACTOR_MAX : cfg.filter_factor;
    for (int k = 0; k < NUM_VAL; k++) begin
      dz_diff[k]  = $signed({a_val_r[k][HELD_W-1], a_val_r[k]})
                  - $signed({held_r[k][HELD_W-1], held_r[k]});
      dz_mag[k]   = dz_diff[k][13] ? 14'(-dz_diff[k]) : 14'(dz_diff[k]);
      held_nxt[k] = (dz_mag[k] > {4'b0, cfg.dead_zone}) ? a_val_r[k] : held_r[k];
      flt_diff[k] = $signed({held_nxt[k][HELD_W-1], held_nxt[k], 4'b0})
                  - $signed({smooth_r[k][SMTH_W-1], smooth_r[k]});
      flt_prod[k] = $signed({1'b0, fac}) * flt_diff[k] + 28'sd128;
      flt_sum[k]  = $signed({{3{smooth_r[k][SMTH_W-1]}}, smooth_r[k]})
                  + $signed(flt_prod[k][27:8]);
      if (flt_sum[k] < SMTH_LO) begin
        smooth_nxt[k] = SMTH_LO[SMTH_W-1:0];
      end else if (flt_sum[k] > SMTH_HI) begin
        smooth_nxt[k] = SMTH_HI[SMTH_W-1:0];
      end else begin
        smooth_nxt[k] = flt_sum[k][SMTH_W-1:0];
      end
    end
  end

  // Update state only for frames with a rectangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VAL; k++) begin
        held_r[k]   <= '0;
        smooth_r[k] <= '0;
      end
    end else if (a_valid_r && a_found_r) begin
      for (int k = 0; k < NUM_VAL; k++) begin
        held_r[k]   <= held_nxt[k];
        smooth_r[k] <= smooth_nxt[k];
      end
    end
  end

  // Saturate to output ranges and form the score
  always_comb begin
    sat_cx = (smooth_r[LANE_CX][16] != smooth_r[LANE_CX][15])
           ? {smooth_r[LANE_CX][16], {(OUT_W-1){~smooth_r[LANE_CX][16]}}}
           : smooth_r[LANE_CX][15:0];
    sat_cy = (smooth_r[LANE_CY][16] != smooth_r[LANE_CY][15])
           ? {smooth_r[LANE_CY][16], {(OUT_W-1){~smooth_r[LANE_CY][16]}}}
           : smooth_r[LANE_CY][15:0];
    sat_w  = smooth_r[LANE_W][16] ? '0 : smooth_r[LANE_W][15:0];
    sat_h  = smooth_r[LANE_H][16] ? '0 : smooth_r[LANE_H][15:0];
    area_q = sat_w * sat_h;
    res_push        = c_valid_r;
    res.found       = c_found_r;
    res.centre_x    = sat_cx;
    res.centre_y    = sat_cy;
    res.face_width  = sat_w;
    res.face_height = sat_h;
    res.score       = area_q[31:8];
  end

  a_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (out_count < CW'(OUT_DEPTH)))
    else $error("result pushed without room");

  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(a_valid_r && a_found_r) |=> ($stable(smooth_r[LANE_W]) && $stable(held_r[LANE_W])))
    else $error("state changed without a rectangle");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |=> c_valid_r)
    else $error("frame lost between stages");

endmodule

`default_nettype wire

### src/face_box_select_and_smooth_core.sv
`default_nettype none

// Channel  | Handshake            | Payload
// input    | push / full          | in_box_valid .. in_frame_end, one rectangle each
// result   | pop / empty          | out_found .. out_score, one per frame-end item
// config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready tied high
//
// One input transaction per cycle while full is low, frame-end or not; the selection compare is combinational.
// A frame's result passes the frame queue, stage A, stage C and the result queue to the result ports.
// rst_n is synchronous; it restores register defaults and clears the tracking state.
// full rises when the four-entry frame queue is full; the tracker draws from it
// only while the result queue has a free entry for every frame in flight.

module face_box_select_and_smooth_core #(
  parameter int unsigned MAX_FRAME_DIM = 2048,
  parameter int unsigned MID_DEPTH     = 4,
  parameter int unsigned OUT_DEPTH     = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         push,
  output logic              full,
  input  wire logic         in_box_valid,
  input  wire logic [9:0]   in_box_left,
  input  wire logic [9:0]   in_box_top,
  input  wire logic [10:0]  in_box_width,
  input  wire logic [10:0]  in_box_height,
  input  wire logic         in_frame_end,
  // result channel
  output logic              empty,
  input  wire logic         pop,
  output logic              out_found,
  output logic signed [15:0] out_centre_x,
  output logic signed [15:0] out_centre_y,
  output logic [15:0]       out_face_width,
  output logic [15:0]       out_face_height,
  output logic [23:0]       out_score,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import fbss_pkg::*;

  localparam int unsigned MCW = $clog2(MID_DEPTH+1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH+1);

  logic [8:0]  filter_factor_r;
  logic [9:0]  dead_zone_r;
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  cfg_t        cfg;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic        in_accept;
  logic        rec_push, rec_pop, mid_empty;
  rec_t        rec_in, rec_out;
  logic [MCW-1:0] mid_count;
  logic        res_push;
  res_t        res_in, res_out;
  logic        out_full;
  logic [OCW-1:0] out_count;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_factor_r <= RST_FILTER_FACTOR;
      dead_zone_r     <= RST_DEAD_ZONE;
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FILTER_FACTOR: filter_factor_r <= pwdata[8:0];
        REG_DEAD_ZONE:     dead_zone_r     <= pwdata[9:0];
        REG_FRAME_WIDTH:   frame_width_r   <= pwdata[11:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_FACTOR: prdata = {23'b0, filter_factor_r};
      REG_DEAD_ZONE:     prdata = {22'b0, dead_zone_r};
      REG_FRAME_WIDTH:   prdata = {20'b0, frame_width_r};
      REG_FRAME_HEIGHT:  prdata = {20'b0, frame_height_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.filter_factor = filter_factor_r;
    cfg.dead_zone     = dead_zone_r;
    cfg.frame_width   = frame_width_r;
    cfg.frame_height  = frame_height_r;
  end

  // Front: select the largest rectangle
  assign in_accept = push && !full;

  fbss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .box_valid  (in_box_valid),
    .box_left   (in_box_left),
    .box_top    (in_box_top),
    .box_width  (in_box_width),
    .box_height (in_box_height),
    .frame_end  (in_frame_end),
    .rec_push   (rec_push),
    .rec        (rec_in)
  );

  // Frame queue between selection and tracking
  fbss_fifo #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec_in),
    .pop   (rec_pop),
    .rdata (rec_out),
    .full  (full),
    .empty (mid_empty),
    .count (mid_count)
  );

  // Back: deadzone, filter and score
  fbss_back #(
    .MAX_FRAME_DIM (MAX_FRAME_DIM),
    .OUT_DEPTH     (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .rec_avail (!mid_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue
  fbss_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  assign out_found       = res_out.found;
  assign out_centre_x    = $signed(res_out.centre_x);
  assign out_centre_y    = $signed(res_out.centre_y);
  assign out_face_width  = res_out.face_width;
  assign out_face_height = res_out.face_height;
  assign out_score       = res_out.score;

  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_count <= MCW'(MID_DEPTH))
    else $error("frame queue over depth");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && out_full))
    else $error("result dropped on full queue");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !in_accept)
    else $error("input taken while full");

endmodule

`default_nettype wire
